>>> design/vts_pkg.sv
package vts_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int DATA_W = 32;
    localparam int FRAC = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W = PROD_W + 2;
    localparam int DEN_W = DATA_W;
    localparam int REM_W = DEN_W + 1;
    localparam int NUM_W = DATA_W + FRAC;
    localparam int DIV_STEPS = NUM_W;
    localparam int XFORM_STAGES = 3;

    typedef logic signed [DATA_W-1:0] coord_t;
    typedef coord_t [3:0] vec_t;
    typedef coord_t [15:0] mat_t;

    localparam coord_t Q_ONE = 32'sh0001_0000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [1:0] MAT_WORLD = 2'd0;
    localparam logic [1:0] MAT_VIEW = 2'd1;
    localparam logic [1:0] MAT_PROJ = 2'd2;
    localparam logic [1:0] MAT_VIEWPORT = 2'd3;

    localparam logic [1:0] SPACE_WORLD = 2'd0;
    localparam logic [1:0] SPACE_VIEW = 2'd1;
    localparam logic [1:0] SPACE_SCREEN = 2'd2;
    localparam logic [1:0] SPACE_NORMAL = 2'd3;

    typedef struct packed {
        vec_t world;
        vec_t view;
        vec_t wn;
    } side_t;

    // clamp a wide signed value to a signed field of the given width
    function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v, input int bits);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed((SUM_W'(1) << (bits - 1)) - SUM_W'(1));
        lo = -hi - SUM_W'(1);
        if (v > hi)
        begin
            return coord_t'(hi[DATA_W-1:0]);
        end
        if (v < lo)
        begin
            return coord_t'(lo[DATA_W-1:0]);
        end
        return coord_t'(v[DATA_W-1:0]);
    endfunction

endpackage

>>> design/vts_if.sv
interface vts_in_if import vts_pkg::*; ();
    logic valid;
    logic ready;
    logic kind;
    logic [1:0] matrix_select;
    logic [3:0] element_index;
    coord_t coefficient;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t norm_x;
    coord_t norm_y;
    coord_t norm_z;

    modport source (output valid, kind, matrix_select, element_index, coefficient,
                    pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, input ready);
    modport sink (input valid, kind, matrix_select, element_index, coefficient,
                  pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, output ready);
endinterface

interface vts_out_if import vts_pkg::*; ();
    logic valid;
    logic ready;
    logic [1:0] space;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    coord_t out_w;
    logic last;

    modport source (output valid, space, out_x, out_y, out_z, out_w, last, input ready);
    modport sink (input valid, space, out_x, out_y, out_z, out_w, last, output ready);
endinterface

>>> design/vts_xform.sv
module vts_xform import vts_pkg::*; #(
    parameter int SAT_BITS = COORD_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   transposed,
    input  logic   in_valid,
    input  vec_t   v_in,
    input  mat_t   m,
    input  side_t  side_in,
    output logic   out_valid,
    output vec_t   v_out,
    output side_t  side_out
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC - 1);

    logic [XFORM_STAGES-1:0] valid_reg;
    side_t side_reg [XFORM_STAGES];
    logic signed [PROD_W-1:0] prod_reg [4][4];
    logic signed [PROD_W-1:0] prod_next [4][4];
    logic signed [SUM_W-1:0] sum_reg [4];
    logic signed [SUM_W-1:0] sum_next [4];
    vec_t out_reg;
    vec_t out_next;

    always_comb
    begin
        logic [3:0] idx;
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                idx = transposed ? 4'(j * 4 + i) : 4'(i * 4 + j);
                prod_next[j][i] = $signed(v_in[i]) * $signed(m[idx]);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            sum_next[j] = SUM_W'(prod_reg[j][0]) + SUM_W'(prod_reg[j][1])
                        + SUM_W'(prod_reg[j][2]) + SUM_W'(prod_reg[j][3]) + ROUND_HALF;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            out_next[j] = sat_coord(sum_reg[j] >>> FRAC, SAT_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[XFORM_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg <= sum_next;
            out_reg <= out_next;
            side_reg[0] <= side_in;
            for (int s = 1; s < XFORM_STAGES; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[XFORM_STAGES-1];
    assign v_out = out_reg;
    assign side_out = side_reg[XFORM_STAGES-1];

endmodule

>>> design/vertex_transform_stage.sv
// channel   dir  handshake      word
// vtx_in    in   valid/ready    kind, matrix_select, element_index, coefficient, pos, norm
// res_out   out  valid/ready    space, out_x, out_y, out_z, out_w, last
//
// a vertex enters in one handshake and leaves as four result words, one per output transfer;
// the single result port sets the sustained rate at one vertex per four result words, while res_out is ready.
// the path is 4*3 transform stages plus the divider stages (one quotient bit per stage).
// a load waits until no vertex is in flight, then writes its coefficient at once.
// rst_n clears the matrix store to zero and all valid bits; a stall freezes every stage.
module vertex_transform_stage import vts_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    vts_in_if.sink vtx_in,
    vts_out_if.source res_out
);

    localparam int SAT_BITS = (COORD_BITS < 16) ? 16 : ((COORD_BITS > 32) ? 32 : COORD_BITS);
    localparam logic [NUM_W-1:0] SAT_HI_U = (NUM_W'(1) << (SAT_BITS - 1)) - NUM_W'(1);
    localparam coord_t SAT_HI_C = coord_t'(SAT_HI_U[DATA_W-1:0]);
    localparam coord_t SAT_LO_C = ~SAT_HI_C;
    localparam int PIPE_DEPTH = 4 * XFORM_STAGES + DIV_STEPS + 2 + 1;
    localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

    mat_t mat_reg [4];
    logic [CNT_W-1:0] cnt_reg;

    logic adv;
    logic take_vertex;
    logic take_load;
    logic last_done;

    vec_t pos_v;
    vec_t nrm_v;
    vec_t world_v;
    vec_t wn_v;
    vec_t view_v;
    vec_t clip_v;
    vec_t screen_v;
    logic world_valid;
    logic view_valid;
    logic clip_valid;
    logic final_valid;
    side_t side_w;
    side_t side_v;
    side_t side_p;
    side_t side_f;

    assign vtx_in.ready = adv && (vtx_in.kind == KIND_VERTEX || cnt_reg == '0);
    assign take_vertex = vtx_in.valid && vtx_in.ready && vtx_in.kind == KIND_VERTEX;
    assign take_load = vtx_in.valid && vtx_in.ready && vtx_in.kind == KIND_LOAD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                mat_reg[k] <= '0;
            end
        end
        else if (take_load)
        begin
            mat_reg[vtx_in.matrix_select][vtx_in.element_index] <= vtx_in.coefficient;
        end
    end

    // vertices in flight, pipeline plus serializer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (take_vertex && !last_done)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (!take_vertex && last_done)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign pos_v = {Q_ONE, vtx_in.pos_z, vtx_in.pos_y, vtx_in.pos_x};
    assign nrm_v = {Q_ONE, vtx_in.norm_z, vtx_in.norm_y, vtx_in.norm_x};

    vts_xform #(.SAT_BITS(SAT_BITS)) u_world_pos (
        .clk(clk), .rst_n(rst_n), .en(adv), .transposed(1'b0),
        .in_valid(take_vertex), .v_in(pos_v), .m(mat_reg[MAT_WORLD]), .side_in('0),
        .out_valid(world_valid), .v_out(world_v), .side_out()
    );

    vts_xform #(.SAT_BITS(SAT_BITS)) u_world_nrm (
        .clk(clk), .rst_n(rst_n), .en(adv), .transposed(1'b0),
        .in_valid(take_vertex), .v_in(nrm_v), .m(mat_reg[MAT_WORLD]), .side_in('0),
        .out_valid(), .v_out(wn_v), .side_out()
    );

    assign side_w = side_t'{world: world_v, view: '0, wn: wn_v};

    vts_xform #(.SAT_BITS(SAT_BITS)) u_view (
        .clk(clk), .rst_n(rst_n), .en(adv), .transposed(1'b1),
        .in_valid(world_valid), .v_in(world_v), .m(mat_reg[MAT_VIEW]), .side_in(side_w),
        .out_valid(view_valid), .v_out(view_v), .side_out(side_v)
    );

    vts_xform #(.SAT_BITS(SAT_BITS)) u_proj (
        .clk(clk), .rst_n(rst_n), .en(adv), .transposed(1'b0),
        .in_valid(view_valid), .v_in(view_v), .m(mat_reg[MAT_PROJ]),
        .side_in(side_t'{world: side_v.world, view: view_v, wn: side_v.wn}),
        .out_valid(clip_valid), .v_out(clip_v), .side_out(side_p)
    );

    // perspective divide: x, y, z over |w|, one quotient bit per stage
    logic [DIV_STEPS:0] dv_valid_reg;
    side_t dv_side_reg [DIV_STEPS+1];
    logic [2:0] dv_neg_reg [DIV_STEPS+1];
    logic [2:0] dv_nz_reg [DIV_STEPS+1];
    logic [DEN_W-1:0] dv_den_reg [DIV_STEPS+1];
    logic [REM_W-1:0] dv_rem_reg [DIV_STEPS+1][3];
    logic [NUM_W-1:0] dv_nq_reg [DIV_STEPS+1][3];

    logic [DEN_W-1:0] den_next;
    logic [DATA_W-1:0] mag_next [3];

    always_comb
    begin
        den_next = clip_v[3][DATA_W-1] ? (~clip_v[3] + 1'b1) : clip_v[3];
        for (int j = 0; j < 3; j++)
        begin
            mag_next[j] = clip_v[j][DATA_W-1] ? (~clip_v[j] + 1'b1) : clip_v[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg <= '0;
        end
        else if (adv)
        begin
            dv_valid_reg <= {dv_valid_reg[DIV_STEPS-1:0], clip_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= side_p;
            dv_den_reg[0] <= den_next;
            for (int j = 0; j < 3; j++)
            begin
                dv_neg_reg[0][j] <= clip_v[j][DATA_W-1];
                dv_nz_reg[0][j] <= (clip_v[j] != '0);
                dv_rem_reg[0][j] <= '0;
                dv_nq_reg[0][j] <= NUM_W'({mag_next[j], FRAC'(0)}) + NUM_W'(den_next >> 1);
            end
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            logic [REM_W-1:0] t;
            if (adv)
            begin
                dv_side_reg[k+1] <= dv_side_reg[k];
                dv_den_reg[k+1] <= dv_den_reg[k];
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_nz_reg[k+1] <= dv_nz_reg[k];
                for (int j = 0; j < 3; j++)
                begin
                    t = {dv_rem_reg[k][j][REM_W-2:0], dv_nq_reg[k][j][NUM_W-1]};
                    if (t >= {1'b0, dv_den_reg[k]})
                    begin
                        dv_rem_reg[k+1][j] <= t - {1'b0, dv_den_reg[k]};
                        dv_nq_reg[k+1][j] <= {dv_nq_reg[k][j][NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[k+1][j] <= t;
                        dv_nq_reg[k+1][j] <= {dv_nq_reg[k][j][NUM_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    vec_t ndc_reg;
    vec_t ndc_next;
    logic ndc_valid_reg;
    side_t ndc_side_reg;

    always_comb
    begin
        logic [NUM_W-1:0] q;
        ndc_next[3] = Q_ONE;
        for (int j = 0; j < 3; j++)
        begin
            q = dv_nq_reg[DIV_STEPS][j];
            if (dv_den_reg[DIV_STEPS] == '0)
            begin
                // zero w: saturate by sign of the numerator
                if (!dv_nz_reg[DIV_STEPS][j])
                begin
                    ndc_next[j] = '0;
                end
                else if (dv_neg_reg[DIV_STEPS][j])
                begin
                    ndc_next[j] = SAT_LO_C;
                end
                else
                begin
                    ndc_next[j] = SAT_HI_C;
                end
            end
            else if (dv_neg_reg[DIV_STEPS][j])
            begin
                if (q > SAT_HI_U + 1'b1)
                begin
                    ndc_next[j] = SAT_LO_C;
                end
                else
                begin
                    ndc_next[j] = ~q[DATA_W-1:0] + 1'b1;
                end
            end
            else if (q > SAT_HI_U)
            begin
                ndc_next[j] = SAT_HI_C;
            end
            else
            begin
                ndc_next[j] = q[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndc_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ndc_valid_reg <= dv_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ndc_reg <= ndc_next;
            ndc_side_reg <= dv_side_reg[DIV_STEPS];
        end
    end

    vts_xform #(.SAT_BITS(SAT_BITS)) u_viewport (
        .clk(clk), .rst_n(rst_n), .en(adv), .transposed(1'b1),
        .in_valid(ndc_valid_reg), .v_in(ndc_reg), .m(mat_reg[MAT_VIEWPORT]),
        .side_in(ndc_side_reg),
        .out_valid(final_valid), .v_out(screen_v), .side_out(side_f)
    );

    // serializer: four result words per vertex
    logic sr_valid_reg;
    logic [1:0] sr_cnt_reg;
    vec_t sr_vec_reg [4];
    logic ser_take;

    assign ser_take = !sr_valid_reg || (sr_cnt_reg == SPACE_NORMAL && res_out.ready);
    assign adv = !final_valid || ser_take;
    assign last_done = res_out.valid && res_out.ready && sr_cnt_reg == SPACE_NORMAL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_valid_reg <= 1'b0;
            sr_cnt_reg <= SPACE_WORLD;
        end
        else if (final_valid && ser_take)
        begin
            sr_valid_reg <= 1'b1;
            sr_cnt_reg <= SPACE_WORLD;
        end
        else if (sr_valid_reg && res_out.ready)
        begin
            if (sr_cnt_reg == SPACE_NORMAL)
            begin
                sr_valid_reg <= 1'b0;
            end
            sr_cnt_reg <= sr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (final_valid && ser_take)
        begin
            sr_vec_reg[SPACE_WORLD] <= side_f.world;
            sr_vec_reg[SPACE_VIEW] <= side_f.view;
            sr_vec_reg[SPACE_SCREEN] <= screen_v;
            sr_vec_reg[SPACE_NORMAL] <= {coord_t'(0), side_f.wn[2], side_f.wn[1], side_f.wn[0]};
        end
    end

    assign res_out.valid = sr_valid_reg;
    assign res_out.space = sr_cnt_reg;
    assign res_out.out_x = sr_vec_reg[sr_cnt_reg][0];
    assign res_out.out_y = sr_vec_reg[sr_cnt_reg][1];
    assign res_out.out_z = sr_vec_reg[sr_cnt_reg][2];
    assign res_out.out_w = sr_vec_reg[sr_cnt_reg][3];
    assign res_out.last = (sr_cnt_reg == SPACE_NORMAL);

endmodule

>>> bench/vts_checker.sv
module vts_checker import vts_pkg::*; (
    input logic clk,
    input logic rst_n,
    vts_in_if.sink vtx_in,
    vts_out_if.sink res_out,
    output int errors,
    output int pending
);

    typedef struct packed {
        logic [1:0] space;
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t w;
        logic last;
    } result_t;

    typedef logic signed [63:0] wide_t;
    typedef wide_t [3:0] wvec_t;

    coord_t coeffs [64];
    result_t expected_results [$];

    function automatic wide_t clamp32(wide_t v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // rounded Q16.16 dot product, hi/lo split so the carry matches exactly
    function automatic wide_t dot_row(wvec_t v, logic [1:0] sel, bit tr, int j);
        wide_t hi_sum;
        wide_t lo_sum;
        wide_t p;
        wide_t h;
        logic [63:0] m;
        int idx;
        hi_sum = 0;
        lo_sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            idx = tr ? (j * 4 + i) : (i * 4 + j);
            p = v[i] * wide_t'(coeffs[sel * 16 + idx]);
            if (p >= 0)
            begin
                h = p >>> 16;
            end
            else
            begin
                m = -p;
                m = (m + 64'hFFFF) >> 16;
                h = -$signed(m);
            end
            hi_sum += h;
            lo_sum += p - h * 65536;
        end
        return clamp32(hi_sum + ((lo_sum + 64'sh8000) >>> 16));
    endfunction

    function automatic wvec_t mul_matrix(wvec_t v, logic [1:0] sel, bit tr);
        wvec_t r;
        for (int j = 0; j < 4; j++)
        begin
            r[j] = dot_row(v, sel, tr, j);
        end
        return r;
    endfunction

    function automatic wide_t persp_divide(wide_t num, wide_t w);
        logic [63:0] d;
        logic [63:0] mag;
        logic [63:0] q;
        d = (w < 0) ? -w : w;
        mag = (num < 0) ? -num : num;
        if (d == 0)
        begin
            if (num > 0) return 64'sd2147483647;
            if (num < 0) return -64'sd2147483648;
            return 0;
        end
        q = ((mag << 16) + d / 2) / d;
        if (num < 0)
        begin
            if (q > 64'd2147483648) return -64'sd2147483648;
            return -$signed(q);
        end
        if (q > 64'd2147483647) return 64'sd2147483647;
        return $signed(q);
    endfunction

    function automatic result_t pack_result(logic [1:0] sp, wvec_t r, logic lst);
        result_t o;
        o.space = sp;
        o.x = coord_t'(r[0]);
        o.y = coord_t'(r[1]);
        o.z = coord_t'(r[2]);
        o.w = coord_t'(r[3]);
        o.last = lst;
        return o;
    endfunction

    task automatic predict_vertex();
        wvec_t pos;
        wvec_t nrm;
        wvec_t wp;
        wvec_t vp;
        wvec_t cp;
        wvec_t ndc;
        wvec_t sp;
        wvec_t wn;
        pos = '{64'sd65536, wide_t'(vtx_in.pos_z), wide_t'(vtx_in.pos_y), wide_t'(vtx_in.pos_x)};
        nrm = '{64'sd65536, wide_t'(vtx_in.norm_z), wide_t'(vtx_in.norm_y),
                wide_t'(vtx_in.norm_x)};
        wp = mul_matrix(pos, MAT_WORLD, 0);
        vp = mul_matrix(wp, MAT_VIEW, 1);
        cp = mul_matrix(vp, MAT_PROJ, 0);
        for (int j = 0; j < 3; j++)
        begin
            ndc[j] = persp_divide(cp[j], cp[3]);
        end
        ndc[3] = 64'sd65536;
        sp = mul_matrix(ndc, MAT_VIEWPORT, 1);
        wn = mul_matrix(nrm, MAT_WORLD, 0);
        wn[3] = 0;
        expected_results.push_back(pack_result(SPACE_WORLD, wp, 1'b0));
        expected_results.push_back(pack_result(SPACE_VIEW, vp, 1'b0));
        expected_results.push_back(pack_result(SPACE_SCREEN, sp, 1'b0));
        expected_results.push_back(pack_result(SPACE_NORMAL, wn, 1'b1));
    endtask

    assign pending = expected_results.size();

    initial
    begin
        errors = 0;
        for (int i = 0; i < 64; i++)
        begin
            coeffs[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && vtx_in.valid && vtx_in.ready)
        begin
            if (vtx_in.kind == KIND_LOAD)
            begin
                coeffs[{vtx_in.matrix_select, vtx_in.element_index}] = vtx_in.coefficient;
            end
            else
            begin
                predict_vertex();
            end
        end
        if (rst_n && res_out.valid && res_out.ready)
        begin
            got = '{res_out.space, res_out.out_x, res_out.out_y, res_out.out_z,
                    res_out.out_w, res_out.last};
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result word %h", got);
                end
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch space %0d: expected %h %h %h %h last %b",
                                 exp_r.space, exp_r.x, exp_r.y, exp_r.z, exp_r.w, exp_r.last);
                        $display("                  actual  %0d %h %h %h %h last %b",
                                 got.space, got.x, got.y, got.z, got.w, got.last);
                    end
                end
            end
        end
    end

endmodule

>>> bench/testbench.sv
module testbench;
    import vts_pkg::*;

    logic clk;
    logic rst_n;
    int errors;
    int pending;
    int hold_cycles;
    bit long_hold_req;
    bit long_hold_done;

    vts_in_if vtx_in ();
    vts_out_if res_out ();

    vertex_transform_stage dut (
        .clk(clk),
        .rst_n(rst_n),
        .vtx_in(vtx_in.sink),
        .res_out(res_out.source)
    );

    vts_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .vtx_in(vtx_in.sink),
        .res_out(res_out.sink),
        .errors(errors),
        .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    function automatic coord_t rand_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return coord_t'($urandom);
            default: return coord_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    // valid stays high after a handshake; the next word or the gap takes over
    task automatic send_word(logic kind, logic [1:0] sel, logic [3:0] idx, coord_t c,
                             coord_t px, coord_t py, coord_t pz,
                             coord_t nx, coord_t ny, coord_t nz);
        int g;
        g = gap_len();
        repeat (g)
        begin
            vtx_in.valid <= 1'b0;
            @(negedge clk);
        end
        vtx_in.valid <= 1'b1;
        vtx_in.kind <= kind;
        vtx_in.matrix_select <= sel;
        vtx_in.element_index <= idx;
        vtx_in.coefficient <= c;
        vtx_in.pos_x <= px;
        vtx_in.pos_y <= py;
        vtx_in.pos_z <= pz;
        vtx_in.norm_x <= nx;
        vtx_in.norm_y <= ny;
        vtx_in.norm_z <= nz;
        @(posedge clk);
        while (!vtx_in.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic load_coeff(logic [1:0] sel, logic [3:0] idx, coord_t c);
        send_word(KIND_LOAD, sel, idx, c, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
    endtask

    task automatic send_vertex(coord_t px, coord_t py, coord_t pz,
                               coord_t nx, coord_t ny, coord_t nz);
        send_word(KIND_VERTEX, 2'($urandom), 4'($urandom), coord_t'($urandom),
                  px, py, pz, nx, ny, nz);
    endtask

    task automatic send_rand_vertex();
        send_vertex(rand_value(), rand_value(), rand_value(),
                    rand_value(), rand_value(), rand_value());
    endtask

    task automatic load_identity(logic [1:0] sel);
        for (int i = 0; i < 16; i++)
        begin
            load_coeff(sel, 4'(i), (i % 5 == 0) ? Q_ONE : 32'sd0);
        end
    endtask

    // receiver stalls, with one long hold-off while the sender keeps pushing
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_out.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_out.ready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            hold_cycles <= 300;
            res_out.ready <= 1'b0;
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            hold_cycles <= $urandom_range(5, 30);
            res_out.ready <= 1'b0;
        end
        else
        begin
            res_out.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        int n;
        int nv;
        rst_n = 1'b0;
        long_hold_req = 0;
        vtx_in.valid = 1'b0;
        vtx_in.kind = KIND_LOAD;
        vtx_in.matrix_select = '0;
        vtx_in.element_index = '0;
        vtx_in.coefficient = '0;
        vtx_in.pos_x = '0;
        vtx_in.pos_y = '0;
        vtx_in.pos_z = '0;
        vtx_in.norm_x = '0;
        vtx_in.norm_y = '0;
        vtx_in.norm_z = '0;
        res_out.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // all-zero matrices: zero w on the divide
        send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0,
                    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0);
        for (int s = 0; s < 4; s++)
        begin
            load_identity(2'(s));
        end
        send_vertex(Q_ONE, -Q_ONE, 32'sh0002_8000, Q_ONE, 32'sd0, -Q_ONE);
        send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        // projection w column zero -> w = 0 with signed x, y, z
        load_coeff(MAT_PROJ, 4'd15, 32'sd0);
        send_vertex(Q_ONE, -Q_ONE, 32'sd0, 32'sd1, -32'sd1, 32'sd0);
        load_coeff(MAT_PROJ, 4'd15, -32'sh0000_8000);
        send_vertex(32'sh0000_0001, 32'sh0000_8000, -32'sh0000_8000, 32'sd0, 32'sd0, 32'sd0);

        // random phases; most are plausible matrices, some extreme
        for (int ph = 0; ph < 4; ph++)
        begin
            n = $urandom_range(4, 16);
            for (int i = 0; i < n; i++)
            begin
                load_coeff(2'($urandom), 4'($urandom),
                           (ph == 3) ? coord_t'($urandom) : rand_value());
            end
            // long phase of vertices only, enough to fill the pipeline
            nv = (ph == 2) ? 80 : 24;
            if (ph == 2)
            begin
                long_hold_req = 1;
            end
            for (int i = 0; i < nv; i++)
            begin
                if (ph != 2 && $urandom_range(0, 9) == 0)
                begin
                    load_coeff(2'($urandom), 4'($urandom), rand_value());
                end
                else
                begin
                    send_rand_vertex();
                end
            end
        end
        vtx_in.valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
design/vts_pkg.sv
design/vts_if.sv
design/vts_xform.sv
design/vertex_transform_stage.sv
bench/vts_checker.sv
bench/testbench.sv
